/* sv/rbfi_pkg.sv */
`timescale 1ns / 1ps

package rbfi_pkg;

    localparam int NUM_AXES      = 3;
    localparam int NUM_FACES     = 6;
    localparam int TOL_WIDTH     = 16;
    localparam int REG_IDX_WIDTH = 3;

    // Configuration register indexes
    localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] REG_BOX_MAX_Z = 3'd5;
    localparam logic [REG_IDX_WIDTH-1:0] REG_TOLERANCE = 3'd6;

    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd7;

endpackage

/* sv/ray_box_face_intersect_top.sv */
`timescale 1ns / 1ps

// Ray against axis-aligned box, nearest face hit, fixed point. One ray beat is
// taken on every cycle that start is high (busy is always low), and its result
// appears on done/hit/distance, one result per ray, in order. The path runs
// through the six face dividers, each a restoring divider with one
// quotient bit per pipeline stage, followed by saturate, multiply, inside test
// and a two-stage nearest-face select. The receiver cannot stall: a result is
// shown for one cycle only and must be captured then. Box and tolerance must be
// written through cfg_we/cfg_index/cfg_data only while no ray is in flight; the
// block itself does not enforce this. Unknown indexes are ignored. A miss
// reports hit = 0 and distance = 0.
module ray_box_face_intersect_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rbfi_pkg::REG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0]               cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_WIDTH-1:0]        origin_x,
    input  logic signed [COORD_WIDTH-1:0]        origin_y,
    input  logic signed [COORD_WIDTH-1:0]        origin_z,
    input  logic signed [COORD_WIDTH-1:0]        dir_x,
    input  logic signed [COORD_WIDTH-1:0]        dir_y,
    input  logic signed [COORD_WIDTH-1:0]        dir_z,
    output logic                                 done,
    output logic                                 hit,
    output logic signed [COORD_WIDTH-1:0]        distance
);
    import rbfi_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int NW = COORD_WIDTH + FRAC_BITS;   // numerator magnitude width
    localparam int PW = 2 * COORD_WIDTH + 2;       // hit point compare width

    // ---------------- configuration ----------------
    logic signed [CW-1:0]  box_min_reg [NUM_AXES];
    logic signed [CW-1:0]  box_max_reg [NUM_AXES];
    logic [TOL_WIDTH-1:0]  tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= CW'(1) << FRAC_BITS;
            end
            tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                REG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                REG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                REG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                REG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                REG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                REG_TOLERANCE: tol_reg <= cfg_data[TOL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline never stalls: every beat is taken.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    logic signed [CW-1:0] in_org [NUM_AXES];
    logic signed [CW-1:0] in_dir [NUM_AXES];
    assign in_org[0] = origin_x;
    assign in_org[1] = origin_y;
    assign in_org[2] = origin_z;
    assign in_dir[0] = dir_x;
    assign in_dir[1] = dir_y;
    assign in_dir[2] = dir_z;

    // ---------------- divider pipeline ----------------
    // Stage index 0 holds the prepared operands, index NW the quotients.
    logic                 vld_reg  [NW+1];
    logic signed [CW-1:0] org_reg  [NW+1][NUM_AXES];
    logic signed [CW-1:0] dir_reg  [NW+1][NUM_AXES];
    logic [CW-1:0]        rem_reg  [NW+1][NUM_FACES];
    logic [NW-1:0]        nq_reg   [NW+1][NUM_FACES];
    logic [CW-1:0]        den_reg  [NW+1][NUM_FACES];
    logic                 neg_reg  [NW+1][NUM_FACES];
    logic                 fv_reg   [NW+1][NUM_FACES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NW; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 0; k < NW; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            org_reg[0][a] <= in_org[a];
            dir_reg[0][a] <= in_dir[a];
            for (int k = 0; k < NW; k++)
            begin
                org_reg[k+1][a] <= org_reg[k][a];
                dir_reg[k+1][a] <= dir_reg[k][a];
            end
        end
    end

    genvar f, k;
    generate
        for (f = 0; f < NUM_FACES; f++) begin : g_face_prep
            localparam int AX = f / 2;
            logic signed [CW:0] plane_ext;
            logic signed [CW:0] diff;
            logic [CW:0]        diff_mag;
            logic [CW:0]        dir_mag;

            always_comb
            begin
                if ((f % 2) == 1)
                    plane_ext = {box_max_reg[AX][CW-1], box_max_reg[AX]};
                else
                    plane_ext = {box_min_reg[AX][CW-1], box_min_reg[AX]};
                diff     = plane_ext - {in_org[AX][CW-1], in_org[AX]};
                diff_mag = diff[CW] ? -diff : diff;
                dir_mag  = in_dir[AX][CW-1] ? -{1'b1, in_dir[AX]} : {1'b0, in_dir[AX]};
            end

            always_ff @(posedge clk)
            begin
                rem_reg[0][f] <= '0;
                nq_reg[0][f]  <= {diff_mag[CW-1:0], {FRAC_BITS{1'b0}}};
                den_reg[0][f] <= dir_mag[CW-1:0];
                neg_reg[0][f] <= diff[CW] ^ in_dir[AX][CW-1];
                fv_reg[0][f]  <= (in_dir[AX] != '0);
            end

            // one quotient bit per stage
            for (k = 0; k < NW; k++) begin : g_div
                logic [CW:0] trial;
                logic [CW:0] diff_t;
                logic        ge;

                always_comb
                begin
                    trial  = {rem_reg[k][f], nq_reg[k][f][NW-1]};
                    diff_t = trial - {1'b0, den_reg[k][f]};
                    ge     = (trial >= {1'b0, den_reg[k][f]});
                end

                always_ff @(posedge clk)
                begin
                    rem_reg[k+1][f] <= ge ? diff_t[CW-1:0] : trial[CW-1:0];
                    nq_reg[k+1][f]  <= {nq_reg[k][f][NW-2:0], ge};
                    den_reg[k+1][f] <= den_reg[k][f];
                    neg_reg[k+1][f] <= neg_reg[k][f];
                    fv_reg[k+1][f]  <= fv_reg[k][f];
                end
            end
        end
    endgenerate

    // ---------------- saturate and skip test ----------------
    logic                 sat_vld_reg;
    logic signed [CW-1:0] sat_org_reg [NUM_AXES];
    logic signed [CW-1:0] sat_dir_reg [NUM_AXES];
    logic signed [CW-1:0] sat_t_reg   [NUM_FACES];
    logic                 sat_cand_reg[NUM_FACES];

    generate
        for (f = 0; f < NUM_FACES; f++) begin : g_sat
            logic [NW-1:0]        q;
            logic                 big;
            logic signed [CW-1:0] t_val;
            logic signed [CW:0]   t_eps;

            always_comb
            begin
                q = nq_reg[NW][f];
                if (neg_reg[NW][f])
                begin
                    // magnitude may reach 2^(CW-1) exactly
                    big = (q[NW-1:CW] != '0) || (q[CW-1] && (q[CW-2:0] != '0));
                    t_val = big ? {1'b1, {(CW-1){1'b0}}} : -q[CW-1:0];
                end
                else
                begin
                    big = (q[NW-1:CW-1] != '0);
                    t_val = big ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
                end
                t_eps = {t_val[CW-1], t_val} + (CW+1)'(tol_reg);
            end

            always_ff @(posedge clk)
            begin
                sat_t_reg[f]    <= t_val;
                sat_cand_reg[f] <= fv_reg[NW][f] && !t_eps[CW];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sat_org_reg[a] <= org_reg[NW][a];
            sat_dir_reg[a] <= dir_reg[NW][a];
        end
    end

    // ---------------- hit point products ----------------
    logic                    mul_vld_reg;
    logic signed [CW-1:0]    mul_org_reg  [NUM_AXES];
    logic signed [2*CW-1:0]  mul_prod_reg [NUM_FACES][NUM_AXES];
    logic signed [CW-1:0]    mul_t_reg    [NUM_FACES];
    logic                    mul_cand_reg [NUM_FACES];

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            mul_org_reg[a] <= sat_org_reg[a];
        end
        for (int i = 0; i < NUM_FACES; i++)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                mul_prod_reg[i][a] <= sat_dir_reg[a] * sat_t_reg[i];
            end
            mul_t_reg[i]    <= sat_t_reg[i];
            mul_cand_reg[i] <= sat_cand_reg[i];
        end
    end

    // ---------------- inside test ----------------
    logic                 tst_vld_reg;
    logic signed [CW-1:0] tst_t_reg    [NUM_FACES];
    logic                 tst_qual_reg [NUM_FACES];

    generate
        for (f = 0; f < NUM_FACES; f++) begin : g_test
            logic signed [PW-1:0] pnt [NUM_AXES];
            logic signed [PW-1:0] lo_ext;
            logic signed [PW-1:0] hi_ext;
            logic signed [PW-1:0] eps_ext;
            logic signed [PW-1:0] margin;
            logic                 in_box;

            always_comb
            begin
                in_box  = 1'b1;
                eps_ext = PW'(tol_reg);
                lo_ext  = '0;
                hi_ext  = '0;
                margin  = '0;
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    // floor of product / 2^FRAC_BITS is an arithmetic shift
                    pnt[a] = PW'(mul_org_reg[a]) + PW'(mul_prod_reg[f][a] >>> FRAC_BITS);
                end
                for (int b = 0; b < NUM_FACES; b++)
                begin
                    if (b != f)
                    begin
                        lo_ext = PW'(box_min_reg[b/2]);
                        hi_ext = PW'(box_max_reg[b/2]);
                        if ((b % 2) == 1)
                            margin = hi_ext - pnt[b/2] + eps_ext;
                        else
                            margin = pnt[b/2] - lo_ext + eps_ext;
                        if (margin[PW-1])
                            in_box = 1'b0;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                tst_t_reg[f]    <= mul_t_reg[f];
                tst_qual_reg[f] <= mul_cand_reg[f] && in_box;
            end
        end
    endgenerate

    // ---------------- nearest face: pairs, then final ----------------
    localparam int NUM_PAIRS = NUM_FACES / 2;

    logic                 min_vld_reg;
    logic signed [CW-1:0] min_t_reg    [NUM_PAIRS];
    logic                 min_qual_reg [NUM_PAIRS];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            if (tst_qual_reg[2*i] &&
                (!tst_qual_reg[2*i+1] || tst_t_reg[2*i] <= tst_t_reg[2*i+1]))
                min_t_reg[i] <= tst_t_reg[2*i];
            else
                min_t_reg[i] <= tst_t_reg[2*i+1];
            min_qual_reg[i] <= tst_qual_reg[2*i] || tst_qual_reg[2*i+1];
        end
    end

    logic                 fin_found;
    logic signed [CW-1:0] fin_t;

    always_comb
    begin
        fin_found = 1'b0;
        fin_t     = '0;
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            if (min_qual_reg[i] && (!fin_found || min_t_reg[i] < fin_t))
            begin
                fin_t     = min_t_reg[i];
                fin_found = 1'b1;
            end
        end
    end

    logic                 done_reg;
    logic                 hit_reg;
    logic signed [CW-1:0] distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
            tst_vld_reg <= 1'b0;
            min_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            sat_vld_reg <= vld_reg[NW];
            mul_vld_reg <= sat_vld_reg;
            tst_vld_reg <= mul_vld_reg;
            min_vld_reg <= tst_vld_reg;
            done_reg    <= min_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= fin_found;
        distance_reg <= fin_found ? fin_t : '0;
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign distance = distance_reg;

endmodule
